### hw/rtl/ffba_pkg.sv
// Shared types, sizes and codes for the first-fit block allocator.
// No dependencies.
package ffba_pkg;

  localparam int MAX_BLOCKS = 64;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int DIV_STEPS  = 32;
  localparam int DCNT_W     = $clog2(DIV_STEPS + 1);
  localparam logic [31:0] CHUNK_RESET = 32'd67108864;

  typedef struct packed {
    logic [31:0] off;
    logic [31:0] size;
    logic        used;
    logic [31:0] owner;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOSPC = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_NOID  = 2'd3;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef logic [4:0] op_t;
  localparam op_t OP_NOP       = 5'd0;
  localparam op_t OP_INIT      = 5'd1;
  localparam op_t OP_CFG       = 5'd2;
  localparam op_t OP_LOAD      = 5'd3;
  localparam op_t OP_RD        = 5'd4;
  localparam op_t OP_NEXT      = 5'd5;
  localparam op_t OP_DIVST     = 5'd6;
  localparam op_t OP_DIVSTEP   = 5'd7;
  localparam op_t OP_ALLOC_WR  = 5'd8;
  localparam op_t OP_MVRD      = 5'd9;
  localparam op_t OP_MVWR      = 5'd10;
  localparam op_t OP_SPLIT_WR  = 5'd11;
  localparam op_t OP_CUR       = 5'd12;
  localparam op_t OP_PRD       = 5'd13;
  localparam op_t OP_PREV      = 5'd14;
  localparam op_t OP_NRD       = 5'd15;
  localparam op_t OP_NXTM      = 5'd16;
  localparam op_t OP_FREE_WR   = 5'd17;
  localparam op_t OP_FREE_DONE = 5'd18;
  localparam op_t OP_RES       = 5'd19;

  typedef struct packed {
    op_t        op;
    logic [1:0] code;
  } cmd_t;

  typedef struct packed {
    logic rd_used;
    logic match;
    logic lt_count;
    logic idx_nz;
    logic div_done;
    logic fit;
    logic split;
    logic full;
    logic mv_more;
    logic next_ok;
    logic out_busy;
  } stat_t;

endpackage

### hw/rtl/ffba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

### hw/rtl/ffba_datapath.sv
// Block table, remainder unit, move counters and result register.
// Depends on ffba_pkg and ffba_ram.
module ffba_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  ffba_pkg::cmd_t      cmd,
  output ffba_pkg::stat_t     stat,
  input  logic [31:0]         cfg_data,
  input  logic                in_action,
  input  logic [31:0]         in_request_size,
  input  logic [16:0]         in_alignment,
  input  logic [31:0]         in_free_id,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output logic [31:0]         out_block_offset,
  output logic [31:0]         out_given_id
);
  import ffba_pkg::*;

  logic [31:0]       chunk_r, chunk_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [31:0]       next_id_r, next_id_nxt;
  logic              act_r, act_nxt;
  logic [31:0]       req_r, req_nxt;
  logic [16:0]       algn_r, algn_nxt;
  logic [31:0]       fid_r, fid_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  entry_t            cur_r, cur_nxt;
  logic [16:0]       rem_r, rem_nxt;
  logic [31:0]       dvd_r, dvd_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic [CNT_W-1:0]  mvk_r, mvk_nxt;
  logic              mvdir_r, mvdir_nxt;
  logic [1:0]        rcnt_r, rcnt_nxt;
  logic              ov_r, ov_nxt;
  logic [1:0]        ost_r, ost_nxt;
  logic [31:0]       ooff_r, ooff_nxt;
  logic [31:0]       oid_r, oid_nxt;

  logic              we, re;
  logic [IDX_W-1:0]  waddr, raddr;
  entry_t            wdata, rdata;

  logic [16:0]       pad;
  logic [31:0]       pad32, avail, aligned;
  logic [17:0]       sh;
  logic              ge;
  logic [CNT_W-1:0]  rc_ext;

  ffba_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BLOCKS)) u_tbl (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(raddr), .rdata(rdata)
  );

  assign pad     = (rem_r == 17'd0) ? 17'd0 : algn_r - rem_r;
  assign pad32   = {15'd0, pad};
  assign avail   = cur_r.size - pad32;
  assign aligned = cur_r.off + pad32;
  assign sh      = {rem_r, dvd_r[31]};
  assign ge      = sh >= {1'b0, algn_r};
  assign rc_ext  = CNT_W'(rcnt_r);

  always_comb begin
    stat.rd_used  = rdata.used;
    stat.match    = rdata.used && (rdata.owner == fid_r);
    stat.lt_count = idx_r < count_r;
    stat.idx_nz   = idx_r != '0;
    stat.div_done = dcnt_r == '0;
    stat.fit      = (pad32 <= cur_r.size) && (avail >= req_r);
    stat.split    = avail != req_r;
    stat.full     = count_r >= CNT_W'(MAX_BLOCKS);
    stat.mv_more  = mvdir_r ? (mvk_r > idx_r + CNT_W'(1)) : (mvk_r + rc_ext < count_r);
    stat.next_ok  = idx_r + CNT_W'(1) + rc_ext < count_r;
    stat.out_busy = ov_r && out_stall;
  end

  always_comb begin
    chunk_nxt   = chunk_r;
    count_nxt   = count_r;
    next_id_nxt = next_id_r;
    act_nxt     = act_r;
    req_nxt     = req_r;
    algn_nxt    = algn_r;
    fid_nxt     = fid_r;
    idx_nxt     = idx_r;
    cur_nxt     = cur_r;
    rem_nxt     = rem_r;
    dvd_nxt     = dvd_r;
    dcnt_nxt    = dcnt_r;
    mvk_nxt     = mvk_r;
    mvdir_nxt   = mvdir_r;
    rcnt_nxt    = rcnt_r;
    ov_nxt      = ov_r && out_stall;
    ost_nxt     = ost_r;
    ooff_nxt    = ooff_r;
    oid_nxt     = oid_r;
    we          = 1'b0;
    re          = 1'b0;
    waddr       = idx_r[IDX_W-1:0];
    raddr       = idx_r[IDX_W-1:0];
    wdata       = cur_r;
    case (cmd.op)
      OP_INIT: begin
        we        = 1'b1;
        waddr     = '0;
        wdata     = '{off: 32'd0, size: chunk_r, used: 1'b0, owner: 32'd0};
        count_nxt = CNT_W'(1);
      end
      OP_CFG: chunk_nxt = cfg_data;
      OP_LOAD: begin
        act_nxt  = in_action;
        req_nxt  = in_request_size;
        algn_nxt = (in_alignment == 17'd0) ? 17'd1 : in_alignment;
        fid_nxt  = in_free_id;
        idx_nxt  = '0;
        rcnt_nxt = '0;
      end
      OP_RD: re = 1'b1;
      OP_NEXT: idx_nxt = idx_r + CNT_W'(1);
      OP_DIVST: begin
        cur_nxt  = rdata;
        rem_nxt  = '0;
        dvd_nxt  = rdata.off;
        dcnt_nxt = DCNT_W'(DIV_STEPS);
      end
      OP_DIVSTEP: begin
        rem_nxt  = ge ? 17'(sh - {1'b0, algn_r}) : sh[16:0];
        dvd_nxt  = {dvd_r[30:0], 1'b0};
        dcnt_nxt = dcnt_r - DCNT_W'(1);
      end
      OP_ALLOC_WR: begin
        we        = 1'b1;
        wdata     = '{off: aligned, size: req_r, used: 1'b1, owner: next_id_r};
        mvk_nxt   = count_r;
        mvdir_nxt = 1'b1;
      end
      OP_MVRD: begin
        re    = 1'b1;
        raddr = mvdir_r ? IDX_W'(mvk_r - CNT_W'(1)) : IDX_W'(mvk_r + rc_ext);
      end
      OP_MVWR: begin
        we      = 1'b1;
        waddr   = mvk_r[IDX_W-1:0];
        wdata   = rdata;
        mvk_nxt = mvdir_r ? mvk_r - CNT_W'(1) : mvk_r + CNT_W'(1);
      end
      OP_SPLIT_WR: begin
        we        = 1'b1;
        waddr     = IDX_W'(idx_r + CNT_W'(1));
        wdata     = '{off: aligned + req_r, size: avail - req_r, used: 1'b0, owner: 32'd0};
        count_nxt = count_r + CNT_W'(1);
      end
      OP_CUR: begin
        cur_nxt       = rdata;
        cur_nxt.used  = 1'b0;
        cur_nxt.owner = '0;
      end
      OP_PRD: begin
        re    = 1'b1;
        raddr = IDX_W'(idx_r - CNT_W'(1));
      end
      OP_PREV: begin
        if (!rdata.used) begin
          cur_nxt.off  = rdata.off;
          cur_nxt.size = cur_r.size + rdata.size;
          idx_nxt      = idx_r - CNT_W'(1);
          rcnt_nxt     = rcnt_r + 2'd1;
        end
      end
      OP_NRD: begin
        re    = 1'b1;
        raddr = IDX_W'(idx_r + CNT_W'(1) + rc_ext);
      end
      OP_NXTM: begin
        if (!rdata.used) begin
          cur_nxt.size = cur_r.size + rdata.size;
          rcnt_nxt     = rcnt_r + 2'd1;
        end
      end
      OP_FREE_WR: begin
        we        = 1'b1;
        mvk_nxt   = idx_r + CNT_W'(1);
        mvdir_nxt = 1'b0;
      end
      OP_FREE_DONE: count_nxt = count_r - rc_ext;
      OP_RES: begin
        ov_nxt  = 1'b1;
        ost_nxt = cmd.code;
        if (cmd.code == ST_OK && act_r == ACT_ALLOC) begin
          ooff_nxt    = aligned;
          oid_nxt     = next_id_r;
          next_id_nxt = next_id_r + 32'd1;
        end else begin
          ooff_nxt = '0;
          oid_nxt  = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_r   <= CHUNK_RESET;
      count_r   <= CNT_W'(1);
      next_id_r <= '0;
      ov_r      <= 1'b0;
      dcnt_r    <= '0;
      mvdir_r   <= 1'b0;
      rcnt_r    <= '0;
    end else begin
      chunk_r   <= chunk_nxt;
      count_r   <= count_nxt;
      next_id_r <= next_id_nxt;
      ov_r      <= ov_nxt;
      dcnt_r    <= dcnt_nxt;
      mvdir_r   <= mvdir_nxt;
      rcnt_r    <= rcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r  <= act_nxt;
    req_r  <= req_nxt;
    algn_r <= algn_nxt;
    fid_r  <= fid_nxt;
    idx_r  <= idx_nxt;
    cur_r  <= cur_nxt;
    rem_r  <= rem_nxt;
    dvd_r  <= dvd_nxt;
    mvk_r  <= mvk_nxt;
    ost_r  <= ost_nxt;
    ooff_r <= ooff_nxt;
    oid_r  <= oid_nxt;
  end

  assign out_valid        = ov_r;
  assign out_status       = ost_r;
  assign out_block_offset = ooff_r;
  assign out_given_id     = oid_r;
endmodule

### hw/rtl/ffba_ctrl.sv
// Sequencer for allocate, free, table init and result hand-off.
// Depends on ffba_pkg.
module ffba_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_action,
  output logic            in_stall,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  ffba_pkg::stat_t stat,
  output ffba_pkg::cmd_t  cmd
);
  import ffba_pkg::*;

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_ARD  = 4'd2;
  localparam logic [3:0] S_ACHK = 4'd3;
  localparam logic [3:0] S_ADIV = 4'd4;
  localparam logic [3:0] S_MVRD = 4'd5;
  localparam logic [3:0] S_MVWR = 4'd6;
  localparam logic [3:0] S_FRD  = 4'd7;
  localparam logic [3:0] S_FCHK = 4'd8;
  localparam logic [3:0] S_PRD  = 4'd9;
  localparam logic [3:0] S_PCHK = 4'd10;
  localparam logic [3:0] S_NRD  = 4'd11;
  localparam logic [3:0] S_NCHK = 4'd12;
  localparam logic [3:0] S_FWR  = 4'd13;
  localparam logic [3:0] S_RES  = 4'd14;

  logic [3:0] state_r, state_nxt;
  logic [1:0] code_r, code_nxt;
  logic       act_r, act_nxt;

  assign cfg_ready = state_r == S_IDLE;
  assign in_stall  = !(state_r == S_IDLE && !cfg_valid);

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    act_nxt   = act_r;
    cmd.op    = OP_NOP;
    cmd.code  = code_r;
    case (state_r)
      S_INIT: begin
        cmd.op    = OP_INIT;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (cfg_valid) begin
          cmd.op    = OP_CFG;
          state_nxt = S_INIT;
        end else if (in_valid) begin
          cmd.op    = OP_LOAD;
          act_nxt   = in_action;
          state_nxt = (in_action == ACT_ALLOC) ? S_ARD : S_FRD;
        end
      end
      S_ARD: begin
        if (!stat.lt_count) begin
          code_nxt  = ST_NOSPC;
          state_nxt = S_RES;
        end else begin
          cmd.op    = OP_RD;
          state_nxt = S_ACHK;
        end
      end
      S_ACHK: begin
        if (stat.rd_used) begin
          cmd.op    = OP_NEXT;
          state_nxt = S_ARD;
        end else begin
          cmd.op    = OP_DIVST;
          state_nxt = S_ADIV;
        end
      end
      S_ADIV: begin
        if (!stat.div_done) begin
          cmd.op = OP_DIVSTEP;
        end else if (!stat.fit) begin
          cmd.op    = OP_NEXT;
          state_nxt = S_ARD;
        end else if (stat.split && stat.full) begin
          code_nxt  = ST_FULL;
          state_nxt = S_RES;
        end else begin
          cmd.op    = OP_ALLOC_WR;
          code_nxt  = ST_OK;
          state_nxt = stat.split ? S_MVRD : S_RES;
        end
      end
      S_MVRD: begin
        if (stat.mv_more) begin
          cmd.op    = OP_MVRD;
          state_nxt = S_MVWR;
        end else begin
          cmd.op    = (act_r == ACT_ALLOC) ? OP_SPLIT_WR : OP_FREE_DONE;
          code_nxt  = ST_OK;
          state_nxt = S_RES;
        end
      end
      S_MVWR: begin
        cmd.op    = OP_MVWR;
        state_nxt = S_MVRD;
      end
      S_FRD: begin
        if (!stat.lt_count) begin
          code_nxt  = ST_NOID;
          state_nxt = S_RES;
        end else begin
          cmd.op    = OP_RD;
          state_nxt = S_FCHK;
        end
      end
      S_FCHK: begin
        if (stat.match) begin
          cmd.op    = OP_CUR;
          state_nxt = stat.idx_nz ? S_PRD : S_NRD;
        end else begin
          cmd.op    = OP_NEXT;
          state_nxt = S_FRD;
        end
      end
      S_PRD: begin
        cmd.op    = OP_PRD;
        state_nxt = S_PCHK;
      end
      S_PCHK: begin
        cmd.op    = OP_PREV;
        state_nxt = S_NRD;
      end
      S_NRD: begin
        if (stat.next_ok) begin
          cmd.op    = OP_NRD;
          state_nxt = S_NCHK;
        end else begin
          state_nxt = S_FWR;
        end
      end
      S_NCHK: begin
        cmd.op    = OP_NXTM;
        state_nxt = S_FWR;
      end
      S_FWR: begin
        cmd.op    = OP_FREE_WR;
        state_nxt = S_MVRD;
      end
      S_RES: begin
        if (!stat.out_busy) begin
          cmd.op    = OP_RES;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
    act_r  <= act_nxt;
  end
endmodule

### hw/rtl/first_fit_block_allocator_unit.sv
// Allocate: accept, scan the blocks in order (32-step remainder unit on each free block), write
// the allocated block, shift table entries up on a split, write the split remainder, post the
// result. Free: search the blocks, merge with free neighbors, shift down the entries after the
// freed one, update the count, post the result. One request at a time; a finished result waits
// in the output register while the next request is taken. Reset and every chunk-length write
// rebuild the table as one free block. Depends on ffba_pkg, ffba_ctrl, ffba_datapath.
module first_fit_block_allocator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [31:0] in_request_size,
  input  logic [16:0] in_alignment,
  input  logic [31:0] in_free_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_block_offset,
  output logic [31:0] out_given_id,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  import ffba_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ffba_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_action(in_action), .in_stall(in_stall),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .stat(stat), .cmd(cmd)
  );

  ffba_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .cfg_data(cfg_data),
    .in_action(in_action), .in_request_size(in_request_size),
    .in_alignment(in_alignment), .in_free_id(in_free_id),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_block_offset(out_block_offset), .out_given_id(out_given_id)
  );
endmodule

### hw/rtl/ffba_checker.sv
// Port-level checks for the allocator, bound to the top level.
// Depends on ffba_pkg and first_fit_block_allocator_unit.
module ffba_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [31:0] out_block_offset,
  input logic [31:0] out_given_id,
  input logic        cfg_valid,
  input logic        cfg_ready
);
  import ffba_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_given_id))
    else $error("stalled result changed");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_block_offset == 32'd0 && out_given_id == 32'd0)
    else $error("failed request carries offset or id");

  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while busy");

  a_cfg_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |-> in_stall)
    else $error("request taken with config write");

  a_cfg_init: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> in_stall && !cfg_ready)
    else $error("table init skipped after config write");
endmodule

bind first_fit_block_allocator_unit ffba_checker u_ffba_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
  .out_block_offset(out_block_offset), .out_given_id(out_given_id),
  .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
);
